// ===== sv/sorted_key_table_assert.svh =====
// Assertion macros for the sorted key table checker.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/skt_pkg.sv =====
// Shared types, codes and elaboration helpers of the sorted key table.
// No dependencies; every module of the block imports this package.
package skt_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int KEY_W            = 31;
  localparam int HANDLE_W         = 16;
  localparam int COUNT_W          = 7;
  localparam int TREE_RADIX       = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] record_handle;
  } skt_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] found_handle;
    logic [COUNT_W-1:0]  entry_count;
  } skt_result_t;

  // Control pulses from the sequencer to every cell.
  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
  } skt_cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                lt;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } skt_link_t;

  // Match flag and gated handle, the leaf of the reduction tree.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
  } skt_leaf_t;

  // Number of nodes at a given level of a radix-8 tree over n leaves.
  function automatic int skt_nodes(input int n, input int level);
    int v;
    v = n;
    for (int s = 0; s < level; s++) begin
      v = (v + TREE_RADIX - 1) / TREE_RADIX;
    end
    return v;
  endfunction

  // Number of registered levels needed to reduce n leaves to one node.
  function automatic int skt_levels(input int n);
    int v;
    int c;
    v = n;
    c = 0;
    for (int s = 0; s < 16; s++) begin
      if (v > 1) begin
        v = (v + TREE_RADIX - 1) / TREE_RADIX;
        c++;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/skt_cell.sv =====
// One entry cell of the sorted key table chain.
// Depends on skt_pkg for the link, leaf and control types.
module skt_cell
  import skt_pkg::*;
(
  input  logic                clk,
  input  skt_cell_ctrl_t      ctrl,
  input  logic                valid,
  input  logic [KEY_W-1:0]    probe_key,
  input  logic [HANDLE_W-1:0] probe_handle,
  input  skt_link_t           left,
  input  skt_link_t           right,
  output skt_link_t           self,
  output skt_leaf_t           leaf
);

  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] handle;
  logic                lt;
  logic                hit_now;

  assign hit_now = valid && (key == probe_key);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt          <= valid && (key < probe_key);
      leaf.hit    <= hit_now;
      leaf.handle <= hit_now ? handle : '0;
    end
    // Insert opens a gap at the first entry not below the key; remove
    // closes the gap at the matching entry by pulling from the right.
    if (ctrl.insert && !lt) begin
      if (left.lt) begin
        key    <= probe_key;
        handle <= probe_handle;
      end else begin
        key    <= left.key;
        handle <= left.handle;
      end
    end else if (ctrl.remove && !lt) begin
      key    <= right.key;
      handle <= right.handle;
    end
  end

  assign self.lt     = lt;
  assign self.key    = key;
  assign self.handle = handle;

endmodule

// ===== sv/skt_or_tree.sv =====
// Registered radix-8 OR tree that merges the cell match leaves.
// Depends on skt_pkg for the leaf type and the tree sizing functions.
module skt_or_tree
  import skt_pkg::*;
#(
  parameter int N = CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  skt_leaf_t leaves [N],
  output skt_leaf_t root
);

  localparam int LEVELS = skt_levels(N);

  skt_leaf_t node [LEVELS][N];

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < skt_nodes(N, l + 1)) begin : g_live
        skt_leaf_t part [TREE_RADIX];
        for (genvar m = 0; m < TREE_RADIX; m++) begin : g_child
          if (j * TREE_RADIX + m < skt_nodes(N, l)) begin : g_src
            if (l == 0) begin : g_leaf
              assign part[m] = leaves[j * TREE_RADIX + m];
            end else begin : g_inner
              assign part[m] = node[l - 1][j * TREE_RADIX + m];
            end
          end else begin : g_pad
            assign part[m] = '0;
          end
        end
        always_ff @(posedge clk) begin
          node[l][j] <= skt_leaf_t'(part[0] | part[1] | part[2] | part[3] |
                                    part[4] | part[5] | part[6] | part[7]);
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          node[l][j] <= '0;
        end
      end
    end
  end

  // At most one cell matches, so the OR yields its handle unchanged.
  assign root = node[LEVELS - 1][0];

endmodule

// ===== sv/sorted_key_table.sv =====
// Top level of the sorted key table: sequencer, entry count and cell chain.
// Depends on skt_pkg, skt_cell and skt_or_tree.
//
//   channel   handshake          payload
//   command   start / busy       item   (skt_item_t: command, key, record_handle)
//   result    done (one cycle)   result (skt_result_t: status, found_handle,
//                                        entry_count)
//
// An item accepted at an edge keeps busy high through the compare cycle,
// the walk up the radix-8 match tree (LEVELS deep, 2 for 64 entries) and
// the commit cycle; no new item is taken while busy is high. The result
// shows on done in the cycle after commit, the same cycle in which the
// next item may be taken. Reset empties the table at once through the
// entry count; the receiver never stalls the block.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  skt_item_t   item,
  output logic        done,
  output skt_result_t result
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = skt_levels(CAPACITY);
  localparam int WW     = $clog2(LEVELS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CMP    = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [WW-1:0] wait_cnt;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  skt_item_t     cur;

  skt_cell_ctrl_t ctrl;
  skt_link_t      links [CAPACITY];
  skt_leaf_t      leaves [CAPACITY];
  skt_leaf_t      root;

  logic [1:0]       status_next;
  logic [HANDLE_W-1:0] handle_next;
  logic             do_insert;
  logic             do_remove;
  logic [CW+COUNT_W-1:0] count_wide;

  assign busy = (state != S_IDLE);

  // Sequencer: latch the item, let every cell compare together, wait for
  // the match tree, then commit the shift and the result together.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_CMP;
      S_CMP:    state_next = S_WAIT;
      S_WAIT:   if (wait_cnt == '0) state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CMP) begin
        wait_cnt <= WW'(LEVELS - 1);
      end else if (state == S_WAIT) begin
        wait_cnt <= wait_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur <= item;
    end
  end

  // Decision at commit. A duplicate is checked before the full table.
  always_comb begin
    status_next = ST_MISSING;
    handle_next = '0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    unique case (cur.command)
      CMD_INSERT: begin
        if (root.hit) begin
          status_next = ST_DUP;
        end else if (count == CW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          do_insert   = 1'b1;
          count_next  = count + 1'b1;
        end
      end
      CMD_FIND: begin
        if (root.hit) begin
          status_next = ST_OK;
          handle_next = root.handle;
        end
      end
      CMD_REMOVE: begin
        if (root.hit) begin
          status_next = ST_OK;
          handle_next = root.handle;
          do_remove   = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_MISSING;
      end
    endcase
  end

  assign count_wide = {{COUNT_W{1'b0}}, count_next};

  assign ctrl.capture = (state == S_CMP);
  assign ctrl.insert  = (state == S_COMMIT) && do_insert;
  assign ctrl.remove  = (state == S_COMMIT) && do_remove;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done   <= 1'b0;
      result <= '0;
    end else begin
      done <= (state == S_COMMIT);
      if (state == S_COMMIT) begin
        count               <= count_next;
        result.status       <= status_next;
        result.found_handle <= handle_next;
        // The count field is the low bits of the entry count.
        result.entry_count  <= count_wide[COUNT_W-1:0];
      end
    end
  end

  // The chain: each cell sees its left and right neighbor. The first cell
  // treats its left side as below the key so that it takes a new item's key,
  // and the last cell pulls nothing meaningful from its right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_link_t left_in;
    skt_link_t right_in;
    logic      cell_valid;

    if (i == 0) begin : g_first
      assign left_in = '{lt: 1'b1, key: '0, handle: '0};
    end else begin : g_mid_l
      assign left_in = links[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = links[i + 1];
    end

    // Entries below the count are live; the rest hold stale data.
    assign cell_valid = (CW'(i) < count);

    skt_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .valid        (cell_valid),
      .probe_key    (cur.key),
      .probe_handle (cur.record_handle),
      .left         (left_in),
      .right        (right_in),
      .self         (links[i]),
      .leaf         (leaves[i])
    );
  end

  skt_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

endmodule

// ===== sv/skt_checker.sv =====
// Port-level checker of the sorted key table, bound to the top level.
// Depends on skt_pkg and the macros in sorted_key_table_assert.svh.
`include "sorted_key_table_assert.svh"

module skt_checker
  import skt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input skt_result_t result
);

  `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `SKT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `SKT_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `SKT_ASSERT_NOW(a_fail_count, done && (result.status != ST_OK), $stable(result.entry_count), "failed command changed the entry count")

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);
